>>> design/shell_sort_engine_assert.svh
// Assertion macros for the shell sort engine.
`ifndef SHELL_SORT_ENGINE_ASSERT_SVH
`define SHELL_SORT_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sse_pkg.sv
// Package: widths, defaults and payload types of the shell sort engine.
`timescale 1ns / 1ps
`default_nettype none
package sse_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } sse_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_res;
    logic                     last_res;
    logic                     overflow;
  } sse_out_t;

endpackage
`default_nettype wire

>>> design/shell_sort_engine.sv
// Top level of the shell sort engine.
//
// Input: an element transfers on a rising edge with start high and busy low.
// Elements fill a store of MAX_ITEMS entries, one per cycle; extra elements
// are dropped and flag overflow on every result of that set.
// The element with last set closes the set; busy then rises and the block
// sorts in place with one signed comparator and one store port pair:
// per gap a pass over the indices; per index the element is held, the one a
// gap before is compared, and larger ones shift up a gap until the element
// is written back (no compare once it reaches the front of its chain).
// Typically about n^1.5 compares, up to n^2 with halving gaps in the worst case.
// Read-out: n results at one per cycle, out_valid high for each,
// last_res on the final one; busy falls in the cycle after the last result.
// Results cannot be held off: each stands for exactly one cycle.
// Reset (synchronous, active low) empties the set and returns to loading;
// store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "shell_sort_engine_assert.svh"
module shell_sort_engine
  import sse_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire sse_in_t in_data,
  output logic         busy,
  output logic         out_valid,
  output sse_out_t     out_data
);

  localparam int ADDR_W = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]        mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  sse_seq #(
    .MAX_ITEMS (MAX_ITEMS),
    .ADDR_W    (ADDR_W),
    .CNT_W     (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sse_store #(
    .DEPTH  (MAX_ITEMS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  `SSE_ASSERT_NOW(a_out_while_busy, out_valid, busy, "result outside sort")
  `SSE_ASSERT_NEXT(a_last_starts_sort, start && !busy && in_data.last, busy, "sort not started")
  `SSE_ASSERT_NEXT(a_last_ends_burst, out_valid && out_data.last_res, !out_valid, "extra result")
  `SSE_ASSERT_NEXT(a_load_no_result, !busy, !out_valid, "result during load")

endmodule
`default_nettype wire

>>> design/sse_store.sv
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sse_store
  import sse_pkg::*;
#(
  parameter int DEPTH  = MAX_ITEMS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic signed [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]        raddr,
  output logic signed [DATA_W-1:0]      rdata
);

  logic signed [DATA_W-1:0] mem_r [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> design/sse_seq.sv
// Sequencer: load, gapped insertion passes with one comparator, and read-out.
`timescale 1ns / 1ps
`default_nettype none
module sse_seq
  import sse_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int ADDR_W    = $clog2(MAX_ITEMS),
  parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire sse_in_t                  in_data,
  output logic                          busy,
  output logic                          out_valid,
  output sse_out_t                      out_data,
  output logic                          mem_we,
  output logic [ADDR_W-1:0]             mem_waddr,
  output logic signed [DATA_W-1:0]      mem_wdata,
  output logic [ADDR_W-1:0]             mem_raddr,
  input  wire logic signed [DATA_W-1:0] mem_rdata
);

  typedef enum logic [2:0] {
    S_LOAD, S_OUTER, S_HELD, S_PROBE, S_CMP, S_EMIT, S_DRAIN
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [CNT_W-1:0]         gap_r, gap_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]         pos_r, pos_nxt;
  logic signed [DATA_W-1:0] held_r, held_nxt;
  logic                     vld_r, vld_nxt;
  logic                     lastr_r, lastr_nxt;
  logic [CNT_W-1:0]         cnt_after;
  logic [CNT_W-1:0]         gap_half;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    gap_nxt   = gap_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    held_nxt  = held_r;
    vld_nxt   = 1'b0;
    lastr_nxt = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_r[ADDR_W-1:0];
    mem_wdata = held_r;
    mem_raddr = idx_r[ADDR_W-1:0];
    cnt_after = count_r;
    gap_half  = gap_r >> 1;
    unique case (state_r)
      S_LOAD: begin
        if (start) begin
          if (count_r < CNT_W'(MAX_ITEMS)) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[ADDR_W-1:0];
            mem_wdata = in_data.value;
            cnt_after = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          count_nxt = cnt_after;
          if (in_data.last) begin
            gap_nxt = cnt_after >> 1;
            idx_nxt = cnt_after >> 1;
            if ((cnt_after >> 1) == '0) begin
              idx_nxt   = '0;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_OUTER;
            end
          end
        end
      end
      S_OUTER: begin
        if (idx_r >= count_r) begin
          gap_nxt = gap_half;
          if (gap_half == '0) begin
            idx_nxt   = '0;
            state_nxt = S_EMIT;
          end else begin
            idx_nxt = gap_half;
          end
        end else begin
          state_nxt = S_HELD;
        end
      end
      S_HELD: begin
        held_nxt  = mem_rdata;
        pos_nxt   = idx_r;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        mem_raddr = ADDR_W'(pos_r - gap_r);
        if (pos_r >= gap_r) begin
          state_nxt = S_CMP;
        end else begin
          mem_we    = 1'b1;
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_OUTER;
        end
      end
      S_CMP: begin
        mem_we = 1'b1;
        if (held_r < mem_rdata) begin
          mem_wdata = mem_rdata;
          pos_nxt   = pos_r - gap_r;
          state_nxt = S_PROBE;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_OUTER;
        end
      end
      S_EMIT: begin
        vld_nxt   = 1'b1;
        lastr_nxt = (idx_r + CNT_W'(1)) == count_r;
        idx_nxt   = idx_r + CNT_W'(1);
        if (lastr_nxt) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      vld_r   <= 1'b0;
      lastr_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      vld_r   <= vld_nxt;
      lastr_r <= lastr_nxt;
    end
    gap_r  <= gap_nxt;
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    held_r <= held_nxt;
  end

  assign busy               = (state_r != S_LOAD);
  assign out_valid          = vld_r;
  assign out_data.value_res = mem_rdata;
  assign out_data.last_res  = lastr_r;
  assign out_data.overflow  = ovf_r;

endmodule
`default_nettype wire
